/* src/assert_macros.svh */
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond implies prop in the same cycle
`define ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// cond implies prop in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

// cond never holds
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

`endif

/* src/abkf_pkg.sv */
// Types, constants and helpers for the angle/bias Kalman filter.
package abkf_pkg;

   localparam int FracBits = 24;
   localparam int DataW    = 32;
   localparam int DtW      = 24;
   localparam int NoiseW   = 31;
   localparam int CsrIdxW  = 2;
   localparam int MulAW    = 35;
   localparam int MulBW    = 32;
   localparam int ProdW    = MulAW + MulBW;
   localparam int ShW      = ProdW - FracBits;
   localparam int SumW     = 48;
   localparam int SW       = DataW + 2;
   localparam int DivNumW  = DataW + FracBits;
   localparam int DivDenW  = 32;
   localparam int DivCntW  = $clog2(DivNumW);

   localparam logic [NoiseW-1:0] AngleNoiseRst = NoiseW'(16777);
   localparam logic [NoiseW-1:0] BiasNoiseRst  = NoiseW'(50331);
   localparam logic [NoiseW-1:0] MeasNoiseRst  = NoiseW'(503316);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ANGLE_NOISE = 2'd0,
      CSR_BIAS_NOISE  = 2'd1,
      CSR_MEAS_NOISE  = 2'd2
   } csr_idx_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_SET, OP_BFR,
      OP_M_ANG, OP_A_ANG, OP_M_SB, OP_A_SB, OP_M_INN, OP_A_AA, OP_M_BB, OP_A_BB,
      OP_INNOV, OP_DIV_GO, OP_DIV_WAIT,
      OP_M_K0I, OP_A_ANG2, OP_M_K1I, OP_A_BIAS,
      OP_M_K1AA, OP_A_BA, OP_M_K1AB, OP_A_BB2,
      OP_M_K0AA, OP_A_AA2, OP_M_K0AB, OP_A_AB2,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rej;
   } dp_cmd_type;

   typedef struct packed {
      logic is_set;
      logic dt_zero;
      logic div_done;
   } dp_status_type;

   function automatic logic signed [DataW-1:0] sat32(input logic signed [SumW-1:0] v);
      logic [SumW-DataW:0] top;
      top = v[SumW-1:DataW-1];
      if (top == '0 || top == '1) return v[DataW-1:0];
      else if (v[SumW-1]) return {1'b1, {(DataW-1){1'b0}}};
      else return {1'b0, {(DataW-1){1'b1}}};
   endfunction

endpackage

/* src/abkf_if.sv */
// Channel interfaces: update requests, results and register writes.
interface abkf_req_if;
   logic                                valid;
   logic                                ready;
   logic                                opcode;
   logic signed [abkf_pkg::DataW-1:0]   measured_angle;
   logic signed [abkf_pkg::DataW-1:0]   measured_rate;
   logic        [abkf_pkg::DtW-1:0]     time_step;
   modport source (output valid, opcode, measured_angle, measured_rate, time_step,
                   input ready);
   modport sink (input valid, opcode, measured_angle, measured_rate, time_step,
                 output ready);
endinterface

interface abkf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [abkf_pkg::DataW-1:0]   angle_estimate;
   logic                                rejected;
   modport source (output valid, angle_estimate, rejected, input ready);
   modport sink (input valid, angle_estimate, rejected, output ready);
endinterface

interface abkf_csr_if;
   logic                                valid;
   logic                                ready;
   logic [abkf_pkg::CsrIdxW-1:0]        index;
   logic [abkf_pkg::NoiseW-1:0]         data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* src/abkf_div.sv */
// Two-lane restoring divider for the Kalman gains, one quotient bit per cycle.
`include "assert_macros.svh"

module abkf_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [abkf_pkg::DataW-1:0]    num0,
   input  logic signed [abkf_pkg::DataW-1:0]    num1,
   input  logic        [abkf_pkg::DivDenW-1:0]  den,
   output logic                                 done,
   output logic signed [abkf_pkg::DataW-1:0]    q0,
   output logic signed [abkf_pkg::DataW-1:0]    q1
);
   localparam int NW = abkf_pkg::DivNumW;
   localparam int DW = abkf_pkg::DivDenW;
   localparam int QW = abkf_pkg::DataW;

   logic                          busy_ff;
   logic                          done_ff;
   logic [abkf_pkg::DivCntW-1:0]  cnt_ff;
   logic [DW-1:0]                 den_ff;
   logic [DW-1:0]                 rem_ff [2];
   logic [NW-1:0]                 quo_ff [2];
   logic                          neg_ff [2];

   logic [DW-1:0]                 rem_in [2];
   logic [NW-1:0]                 quo_in [2];
   logic [QW-1:0]                 mag    [2];
   logic signed [QW-1:0]          q_sat  [2];
   logic signed [QW-1:0]          num    [2];

   assign num[0] = num0;
   assign num[1] = num1;

   always_comb begin
      logic [DW:0] rem_sh;
      logic        ge;
      for (int i = 0; i < 2; i++) begin
         rem_sh    = {rem_ff[i], quo_ff[i][NW-1]};
         ge        = rem_sh >= {1'b0, den_ff};
         rem_in[i] = ge ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
         quo_in[i] = {quo_ff[i][NW-2:0], ge};
         mag[i]    = num[i][QW-1] ? QW'(-num[i]) : QW'(num[i]);
         // truncate toward zero, then clamp to 32-bit signed
         if (!neg_ff[i]) begin
            if (quo_ff[i][NW-1:QW-1] != '0) q_sat[i] = {1'b0, {(QW-1){1'b1}}};
            else q_sat[i] = quo_ff[i][QW-1:0];
         end else begin
            if (quo_ff[i][NW-1:QW] != '0 || (quo_ff[i][QW-1] && quo_ff[i][QW-2:0] != '0))
               q_sat[i] = {1'b1, {(QW-1){1'b0}}};
            else
               q_sat[i] = QW'(-quo_ff[i][QW-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == abkf_pkg::DivCntW'(NW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         for (int i = 0; i < 2; i++) begin
            rem_ff[i] <= '0;
            quo_ff[i] <= {mag[i], {abkf_pkg::FracBits{1'b0}}};
            neg_ff[i] <= num[i][QW-1];
         end
      end else if (busy_ff) begin
         for (int i = 0; i < 2; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   assign done = done_ff;
   assign q0   = q_sat[0];
   assign q1   = q_sat[1];

   `ASSERT_NEVER(a_div_restart, clock, reset, start && busy_ff)
   `ASSERT_IMPL(a_div_done_idle, clock, reset, done_ff, !busy_ff)
   `ASSERT_NEXT(a_div_start_busy, clock, reset, start, busy_ff)

endmodule

/* src/abkf_dp.sv */
// Datapath: filter state, noise registers, shared multiplier and gain divider.
module abkf_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  abkf_pkg::dp_cmd_type                 cmd,
   output abkf_pkg::dp_status_type              status,
   input  logic                                 opcode,
   input  logic signed [abkf_pkg::DataW-1:0]    measured_angle,
   input  logic signed [abkf_pkg::DataW-1:0]    measured_rate,
   input  logic        [abkf_pkg::DtW-1:0]      time_step,
   input  logic                                 csr_we,
   input  logic        [abkf_pkg::CsrIdxW-1:0]  csr_index,
   input  logic        [abkf_pkg::NoiseW-1:0]   csr_data,
   output logic signed [abkf_pkg::DataW-1:0]    angle_estimate,
   output logic                                 rejected
);
   localparam int DW  = abkf_pkg::DataW;
   localparam int SmW = abkf_pkg::SumW;
   localparam int AW  = abkf_pkg::MulAW;
   localparam int BW  = abkf_pkg::MulBW;
   localparam int SW  = abkf_pkg::SW;

   logic [abkf_pkg::NoiseW-1:0]  apn_ff, bpn_ff, mn_ff;
   logic signed [DW-1:0]         angle_ff, bias_ff, bfr_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic                         op_ff;
   logic signed [DW-1:0]         meas_ff, rate_ff;
   logic [abkf_pkg::DtW-1:0]     dt_ff;
   logic signed [abkf_pkg::ShW-1:0] prod_ff;
   logic signed [DW-1:0]         sb_ff, innov_ff, k0_ff, k1_ff;
   logic signed [AW-1:0]         inner_ff;
   logic signed [SW-1:0]         s_ff;
   logic signed [DW-1:0]         rsp_angle_ff;
   logic                         rsp_rej_ff;

   logic signed [AW-1:0]                 mul_a;
   logic signed [BW-1:0]                 mul_b;
   logic signed [abkf_pkg::ProdW-1:0]    product;
   logic signed [SmW-1:0]                prod_x;
   logic signed [BW-1:0]                 dt_s;
   logic                                 s_pos;
   logic                                 div_done;
   logic signed [DW-1:0]                 q0, q1;

   assign dt_s  = signed'(BW'(dt_ff));
   assign prod_x = SmW'(prod_ff);
   assign s_pos = !s_ff[SW-1] && (s_ff != '0);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         abkf_pkg::OP_M_ANG:  begin mul_a = AW'(bfr_ff);               mul_b = dt_s;     end
         abkf_pkg::OP_M_SB:   begin mul_a = AW'(bb_ff);                mul_b = dt_s;     end
         abkf_pkg::OP_M_INN:  begin mul_a = inner_ff;                  mul_b = dt_s;     end
         abkf_pkg::OP_M_BB:   begin mul_a = signed'(AW'(bpn_ff));      mul_b = dt_s;     end
         abkf_pkg::OP_M_K0I:  begin mul_a = AW'(k0_ff);                mul_b = innov_ff; end
         abkf_pkg::OP_M_K1I:  begin mul_a = AW'(k1_ff);                mul_b = innov_ff; end
         abkf_pkg::OP_M_K1AA: begin mul_a = AW'(k1_ff);                mul_b = aa_ff;    end
         abkf_pkg::OP_M_K1AB: begin mul_a = AW'(k1_ff);                mul_b = ab_ff;    end
         abkf_pkg::OP_M_K0AA: begin mul_a = AW'(k0_ff);                mul_b = aa_ff;    end
         abkf_pkg::OP_M_K0AB: begin mul_a = AW'(k0_ff);                mul_b = ab_ff;    end
         default: ;
      endcase
   end

   assign product = abkf_pkg::ProdW'(mul_a) * abkf_pkg::ProdW'(mul_b);

   abkf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == abkf_pkg::OP_DIV_GO),
      .num0  (aa_ff),
      .num1  (ba_ff),
      .den   (s_ff[abkf_pkg::DivDenW-1:0]),
      .done  (div_done),
      .q0    (q0),
      .q1    (q1)
   );

   // product register: arithmetic shift gives the floor
   always_ff @(posedge clock) begin
      prod_ff <= product[abkf_pkg::ProdW-1:abkf_pkg::FracBits];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         apn_ff   <= abkf_pkg::AngleNoiseRst;
         bpn_ff   <= abkf_pkg::BiasNoiseRst;
         mn_ff    <= abkf_pkg::MeasNoiseRst;
         angle_ff <= '0;
         bias_ff  <= '0;
         bfr_ff   <= '0;
         aa_ff    <= '0;
         ab_ff    <= '0;
         ba_ff    <= '0;
         bb_ff    <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               abkf_pkg::CSR_ANGLE_NOISE: apn_ff <= csr_data;
               abkf_pkg::CSR_BIAS_NOISE:  bpn_ff <= csr_data;
               abkf_pkg::CSR_MEAS_NOISE:  mn_ff  <= csr_data;
               default: ;
            endcase
         end
         case (cmd.op)
            abkf_pkg::OP_SET:   angle_ff <= meas_ff;
            abkf_pkg::OP_BFR:   bfr_ff   <= abkf_pkg::sat32(SmW'(rate_ff) - SmW'(bias_ff));
            abkf_pkg::OP_A_ANG: angle_ff <= abkf_pkg::sat32(SmW'(angle_ff) + prod_x);
            abkf_pkg::OP_A_AA: begin
               aa_ff <= abkf_pkg::sat32(SmW'(aa_ff) + prod_x);
               ab_ff <= abkf_pkg::sat32(SmW'(ab_ff) - SmW'(sb_ff));
               ba_ff <= abkf_pkg::sat32(SmW'(ba_ff) - SmW'(sb_ff));
            end
            abkf_pkg::OP_A_BB:   bb_ff    <= abkf_pkg::sat32(SmW'(bb_ff) + prod_x);
            abkf_pkg::OP_A_ANG2: angle_ff <= abkf_pkg::sat32(SmW'(angle_ff) + prod_x);
            abkf_pkg::OP_A_BIAS: bias_ff  <= abkf_pkg::sat32(SmW'(bias_ff) + prod_x);
            abkf_pkg::OP_A_BA:   ba_ff    <= abkf_pkg::sat32(SmW'(ba_ff) - prod_x);
            abkf_pkg::OP_A_BB2:  bb_ff    <= abkf_pkg::sat32(SmW'(bb_ff) - prod_x);
            abkf_pkg::OP_A_AA2:  aa_ff    <= abkf_pkg::sat32(SmW'(aa_ff) - prod_x);
            abkf_pkg::OP_A_AB2:  ab_ff    <= abkf_pkg::sat32(SmW'(ab_ff) - prod_x);
            default: ;
         endcase
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      case (cmd.op)
         abkf_pkg::OP_LOAD: begin
            op_ff   <= opcode;
            meas_ff <= measured_angle;
            rate_ff <= measured_rate;
            dt_ff   <= time_step;
         end
         abkf_pkg::OP_A_SB: begin
            sb_ff    <= prod_ff[DW-1:0];
            inner_ff <= AW'(prod_ff) - AW'(ab_ff) - AW'(ba_ff) + signed'(AW'(apn_ff));
         end
         abkf_pkg::OP_INNOV: begin
            innov_ff <= abkf_pkg::sat32(SmW'(meas_ff) - SmW'(angle_ff));
            s_ff     <= SW'(aa_ff) + signed'(SW'(mn_ff));
         end
         abkf_pkg::OP_DIV_WAIT: begin
            if (div_done) begin
               k0_ff <= s_pos ? q0 : '0;
               k1_ff <= s_pos ? q1 : '0;
            end
         end
         abkf_pkg::OP_OUT: begin
            rsp_angle_ff <= cmd.rej ? '0 : angle_ff;
            rsp_rej_ff   <= cmd.rej;
         end
         default: ;
      endcase
   end

   assign status.is_set   = op_ff;
   assign status.dt_zero  = (dt_ff == '0);
   assign status.div_done = div_done;
   assign angle_estimate  = rsp_angle_ff;
   assign rejected        = rsp_rej_ff;

endmodule

/* src/abkf_ctrl.sv */
// Sequencer for the filter update: handshakes and datapath commands.
`include "assert_macros.svh"

module abkf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  abkf_pkg::dp_status_type  status,
   output abkf_pkg::dp_cmd_type     cmd
);
   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_SET, ST_BFR,
      ST_M_ANG, ST_A_ANG, ST_M_SB, ST_A_SB, ST_M_INN, ST_A_AA, ST_M_BB, ST_A_BB,
      ST_INNOV, ST_DIV_GO, ST_DIV_WAIT,
      ST_M_K0I, ST_A_ANG2, ST_M_K1I, ST_A_BIAS,
      ST_M_K1AA, ST_A_BA, ST_M_K1AB, ST_A_BB2,
      ST_M_K0AA, ST_A_AA2, ST_M_K0AB, ST_A_AB2,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rej_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.rej = rej_ff;
      unique case (state_ff)
         ST_IDLE:     cmd.op = req_valid ? abkf_pkg::OP_LOAD : abkf_pkg::OP_NONE;
         ST_CHECK:    cmd.op = abkf_pkg::OP_NONE;
         ST_SET:      cmd.op = abkf_pkg::OP_SET;
         ST_BFR:      cmd.op = abkf_pkg::OP_BFR;
         ST_M_ANG:    cmd.op = abkf_pkg::OP_M_ANG;
         ST_A_ANG:    cmd.op = abkf_pkg::OP_A_ANG;
         ST_M_SB:     cmd.op = abkf_pkg::OP_M_SB;
         ST_A_SB:     cmd.op = abkf_pkg::OP_A_SB;
         ST_M_INN:    cmd.op = abkf_pkg::OP_M_INN;
         ST_A_AA:     cmd.op = abkf_pkg::OP_A_AA;
         ST_M_BB:     cmd.op = abkf_pkg::OP_M_BB;
         ST_A_BB:     cmd.op = abkf_pkg::OP_A_BB;
         ST_INNOV:    cmd.op = abkf_pkg::OP_INNOV;
         ST_DIV_GO:   cmd.op = abkf_pkg::OP_DIV_GO;
         ST_DIV_WAIT: cmd.op = abkf_pkg::OP_DIV_WAIT;
         ST_M_K0I:    cmd.op = abkf_pkg::OP_M_K0I;
         ST_A_ANG2:   cmd.op = abkf_pkg::OP_A_ANG2;
         ST_M_K1I:    cmd.op = abkf_pkg::OP_M_K1I;
         ST_A_BIAS:   cmd.op = abkf_pkg::OP_A_BIAS;
         ST_M_K1AA:   cmd.op = abkf_pkg::OP_M_K1AA;
         ST_A_BA:     cmd.op = abkf_pkg::OP_A_BA;
         ST_M_K1AB:   cmd.op = abkf_pkg::OP_M_K1AB;
         ST_A_BB2:    cmd.op = abkf_pkg::OP_A_BB2;
         ST_M_K0AA:   cmd.op = abkf_pkg::OP_M_K0AA;
         ST_A_AA2:    cmd.op = abkf_pkg::OP_A_AA2;
         ST_M_K0AB:   cmd.op = abkf_pkg::OP_M_K0AB;
         ST_A_AB2:    cmd.op = abkf_pkg::OP_A_AB2;
         ST_FINISH:   cmd.op = out_free ? abkf_pkg::OP_OUT : abkf_pkg::OP_NONE;
         default:     cmd.op = abkf_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rej_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FINISH && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE:   if (req_valid) state_ff <= ST_CHECK;
            ST_CHECK: begin
               rej_ff <= !status.is_set && status.dt_zero;
               if (status.is_set) begin
                  state_ff <= ST_SET;
               end else if (status.dt_zero) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_BFR;
               end
            end
            ST_SET:    state_ff <= ST_FINISH;
            ST_BFR:    state_ff <= ST_M_ANG;
            ST_M_ANG:  state_ff <= ST_A_ANG;
            ST_A_ANG:  state_ff <= ST_M_SB;
            ST_M_SB:   state_ff <= ST_A_SB;
            ST_A_SB:   state_ff <= ST_M_INN;
            ST_M_INN:  state_ff <= ST_A_AA;
            ST_A_AA:   state_ff <= ST_M_BB;
            ST_M_BB:   state_ff <= ST_A_BB;
            ST_A_BB:   state_ff <= ST_INNOV;
            ST_INNOV:  state_ff <= ST_DIV_GO;
            ST_DIV_GO: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: if (status.div_done) state_ff <= ST_M_K0I;
            ST_M_K0I:  state_ff <= ST_A_ANG2;
            ST_A_ANG2: state_ff <= ST_M_K1I;
            ST_M_K1I:  state_ff <= ST_A_BIAS;
            // bias-row covariance first, it needs the old aa and ab
            ST_A_BIAS: state_ff <= ST_M_K1AA;
            ST_M_K1AA: state_ff <= ST_A_BA;
            ST_A_BA:   state_ff <= ST_M_K1AB;
            ST_M_K1AB: state_ff <= ST_A_BB2;
            ST_A_BB2:  state_ff <= ST_M_K0AA;
            ST_M_K0AA: state_ff <= ST_A_AA2;
            ST_A_AA2:  state_ff <= ST_M_K0AB;
            ST_M_K0AB: state_ff <= ST_A_AB2;
            ST_A_AB2:  state_ff <= ST_FINISH;
            ST_FINISH: if (out_free) state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_NEXT(a_accept_to_check, clock, reset, req_valid && req_ready, state_ff == ST_CHECK)
   `ASSERT_IMPL(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH)
   `ASSERT_NEXT(a_div_exit, clock, reset, state_ff == ST_DIV_WAIT && status.div_done, state_ff == ST_M_K0I)

endmodule

/* src/angle_bias_kalman_filter.sv */
// Update item: the gain divider dominates the time from accepted beat to result beat.
// Set-angle and zero-time-step items skip the prediction, the divider and the gain update.
// One item in flight; the next beat is taken as soon as the result is in the output register.
// Synchronous active-high reset zeroes angle, bias and covariance and loads default noise values.
module angle_bias_kalman_filter (
   input  logic             clock,
   input  logic             reset,
   abkf_req_if.sink         req_ch,
   abkf_rsp_if.source       rsp_ch,
   abkf_csr_if.sink         csr_ch
);
   abkf_pkg::dp_cmd_type     cmd;
   abkf_pkg::dp_status_type  status;

   assign csr_ch.ready = 1'b1;

   abkf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   abkf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .opcode         (req_ch.opcode),
      .measured_angle (req_ch.measured_angle),
      .measured_rate  (req_ch.measured_rate),
      .time_step      (req_ch.time_step),
      .csr_we         (csr_ch.valid),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .angle_estimate (rsp_ch.angle_estimate),
      .rejected       (rsp_ch.rejected)
   );

endmodule

/* tb/sv/abkf_scoreboard.sv */
`timescale 1ns / 1ps
// Watches the filter channels, predicts each result and compares it with the result beat.
module abkf_scoreboard (
   input  logic clock,
   input  logic reset,
   abkf_req_if  req_ch,
   abkf_rsp_if  rsp_ch,
   abkf_csr_if  csr_ch,
   output int   errors,
   output int   pending
);
   typedef struct {
      logic signed [abkf_pkg::DataW-1:0] angle;
      logic                              rejected;
   } angle_result_type;

   angle_result_type expected_q[$];

   longint q_angle, q_bias, r_meas;
   int     ang, bias, rate_nb, p_aa, p_ab, p_ba, p_bb;

   function automatic int clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   // Q8.24 product, floor rounding
   function automatic longint qmul(input longint a, input longint b);
      return (a * b) >>> abkf_pkg::FracBits;
   endfunction

   function automatic int kgain(input int num, input longint den);
      if (den <= 0) return 0;
      return clamp32((longint'(num) <<< abkf_pkg::FracBits) / den);
   endfunction

   function automatic angle_result_type filter_step(input logic op, input int meas_a,
                                                    input int meas_r, input longint dt);
      angle_result_type res;
      longint inner, step_b, s;
      int innov, k0, k1, p00, p01;
      res.rejected = 1'b0;
      if (op) begin
         ang = meas_a;
         res.angle = ang;
         return res;
      end
      if (dt == 0) begin
         res.angle = '0;
         res.rejected = 1'b1;
         return res;
      end
      rate_nb = clamp32(longint'(meas_r) - bias);
      ang = clamp32(longint'(ang) + qmul(dt, rate_nb));
      inner = qmul(dt, p_bb) - p_ab - p_ba + q_angle;
      step_b = qmul(dt, p_bb);
      p_aa = clamp32(longint'(p_aa) + qmul(dt, inner));
      p_ab = clamp32(longint'(p_ab) - step_b);
      p_ba = clamp32(longint'(p_ba) - step_b);
      p_bb = clamp32(longint'(p_bb) + qmul(q_bias, dt));
      innov = clamp32(longint'(meas_a) - ang);
      s = longint'(p_aa) + r_meas;
      k0 = kgain(p_aa, s);
      k1 = kgain(p_ba, s);
      p00 = p_aa;
      p01 = p_ab;
      ang = clamp32(longint'(ang) + qmul(k0, innov));
      bias = clamp32(longint'(bias) + qmul(k1, innov));
      p_aa = clamp32(longint'(p00) - qmul(k0, p00));
      p_ab = clamp32(longint'(p01) - qmul(k0, p01));
      p_ba = clamp32(longint'(p_ba) - qmul(k1, p00));
      p_bb = clamp32(longint'(p_bb) - qmul(k1, p01));
      res.angle = ang;
      return res;
   endfunction

   always @(posedge clock) begin
      angle_result_type exp_r;
      if (reset) begin
         q_angle = abkf_pkg::AngleNoiseRst;
         q_bias = abkf_pkg::BiasNoiseRst;
         r_meas = abkf_pkg::MeasNoiseRst;
         {ang, bias, rate_nb, p_aa, p_ab, p_ba, p_bb} = '0;
         expected_q.delete();
         errors <= 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               abkf_pkg::CSR_ANGLE_NOISE: q_angle = longint'(csr_ch.data);
               abkf_pkg::CSR_BIAS_NOISE:  q_bias = longint'(csr_ch.data);
               abkf_pkg::CSR_MEAS_NOISE:  r_meas = longint'(csr_ch.data);
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            expected_q.push_back(filter_step(req_ch.opcode, req_ch.measured_angle,
                                             req_ch.measured_rate,
                                             longint'(req_ch.time_step)));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: result beat with nothing expected: angle %0d rejected %0b",
                        $time, rsp_ch.angle_estimate, rsp_ch.rejected);
               errors <= errors + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_ch.angle_estimate !== exp_r.angle ||
                   rsp_ch.rejected !== exp_r.rejected) begin
                  $display("%0t: mismatch: expected angle %0d rejected %0b, got %0d %0b",
                           $time, exp_r.angle, exp_r.rejected,
                           rsp_ch.angle_estimate, rsp_ch.rejected);
                  errors <= errors + 1;
               end
            end
         end
      end
      pending <= expected_q.size();
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Top of the filter testbench: clock, reset, stimulus, result backpressure and verdict.
module testbench;
   localparam logic [abkf_pkg::CsrIdxW-1:0] CsrUnused = 2'd3;
   localparam int RandomPerPhase = 270;
   localparam int CycleLimit = 2000000;
   localparam int SettleCycles = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors, pending;
   int   cycles = 0;

   abkf_req_if req_ch ();
   abkf_rsp_if rsp_ch ();
   abkf_csr_if csr_ch ();

   angle_bias_kalman_filter DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   abkf_scoreboard checker_i (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch),
      .errors(errors), .pending(pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("testbench failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_item(input logic op, input int ma, input int mr, input int dt);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.measured_angle <= ma;
      req_ch.measured_rate <= mr;
      req_ch.time_step <= dt[abkf_pkg::DtW-1:0];
      do @(posedge clock); while (!req_ch.ready);
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random();
      int r, ma, mr, dt;
      r = $urandom_range(0, 99);
      ma = ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 23592960)) - 11796480
                                       : int'($urandom);
      mr = ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 65536000)) - 32768000
                                       : int'($urandom);
      if (r >= 8 && r < 12) dt = 0;
      else if (r < 20) dt = $urandom_range(0, 16777215);
      else dt = $urandom_range(1000, 400000);
      send_item(r < 8, ma, mr, dt);
   endtask

   task automatic write_reg(input logic [abkf_pkg::CsrIdxW-1:0] idx,
                            input logic [abkf_pkg::NoiseW-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // all results in, then let a possible in-flight update finish
   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // results side: random stalls, quiet stretches, one long hold-off
   initial begin
      int seen, hold_left, calm_left, r;
      bit held;
      seen = 0; hold_left = 0; calm_left = 0; held = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) seen++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (seen >= 500 && !held) begin
            held = 1;
            hold_left = 600;
            rsp_ch.ready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_ch.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 8) calm_left = $urandom_range(20, 200);
            if (r >= 97) hold_left = $urandom_range(20, 80);
            rsp_ch.ready <= (r >= 30);
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.opcode = 1'b0;
      req_ch.measured_angle = '0;
      req_ch.measured_rate = '0;
      req_ch.time_step = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, both operations, rejection
      send_item(1'b0, 32'sh00010000, 32'sh00000000, 100000);
      send_item(1'b0, 0, 0, 0);
      send_item(1'b1, 32'sh7fffffff, 32'sh80000000, 0);
      send_item(1'b1, 32'sh80000000, 32'sh7fffffff, 24'hffffff);
      send_item(1'b0, 32'sh7fffffff, 32'sh7fffffff, 24'hffffff);
      send_item(1'b0, 32'sh80000000, 32'sh80000000, 24'hffffff);
      send_item(1'b0, 32'sh80000000, 32'sh7fffffff, 1);
      send_item(1'b1, 0, 0, 0);
      send_item(1'b0, 32'sh7fffffff, 0, 0);
      send_item(1'b0, 0, 32'sh7fffffff, 24'hffffff);
      send_item(1'b0, 0, 32'sh80000000, 24'hffffff);
      send_item(1'b1, 32'sh00b40000, 0, 24'h000001);
      send_item(1'b0, 32'sh00b00000, 32'sh00020000, 16777);
      send_item(1'b0, -32'sh00b00000, -32'sh00020000, 16777);
      send_item(1'b0, 32'sh00010000, 32'sh00000000, 24'h800000);
      send_item(1'b0, 32'sh7fffffff, 32'sh7fffffff, 1);
      send_item(1'b0, 0, 0, 24'h000001);
      send_item(1'b1, 32'sh12345678, 32'sh00000000, 24'h000000);

      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            req_ch.valid <= 1'b0;
            drain();
            case (ph)
               1: begin
                  write_reg(abkf_pkg::CSR_ANGLE_NOISE, '1);
                  write_reg(abkf_pkg::CSR_BIAS_NOISE, '1);
                  write_reg(abkf_pkg::CSR_MEAS_NOISE, '1);
               end
               2: begin
                  write_reg(abkf_pkg::CSR_ANGLE_NOISE, '0);
                  write_reg(abkf_pkg::CSR_BIAS_NOISE, '0);
                  write_reg(abkf_pkg::CSR_MEAS_NOISE, '0);
                  write_reg(CsrUnused, '1);
               end
               3: begin
                  write_reg(abkf_pkg::CSR_ANGLE_NOISE, abkf_pkg::NoiseW'($urandom));
                  write_reg(abkf_pkg::CSR_BIAS_NOISE, abkf_pkg::NoiseW'($urandom));
                  write_reg(abkf_pkg::CSR_MEAS_NOISE, abkf_pkg::NoiseW'($urandom));
               end
               4: begin
                  write_reg(abkf_pkg::CSR_ANGLE_NOISE,
                            abkf_pkg::NoiseW'($urandom_range(0, 200000)));
                  write_reg(abkf_pkg::CSR_BIAS_NOISE,
                            abkf_pkg::NoiseW'($urandom_range(0, 200000)));
                  write_reg(abkf_pkg::CSR_MEAS_NOISE,
                            abkf_pkg::NoiseW'($urandom_range(0, 2000000)));
               end
               default: begin
                  write_reg(abkf_pkg::CSR_ANGLE_NOISE, abkf_pkg::AngleNoiseRst);
                  write_reg(abkf_pkg::CSR_BIAS_NOISE, abkf_pkg::BiasNoiseRst);
                  write_reg(abkf_pkg::CSR_MEAS_NOISE, abkf_pkg::MeasNoiseRst);
                  write_reg(CsrUnused, '0);
               end
            endcase
            // re-anchor the angle before the new phase
            send_item(1'b1, 0, 0, 0);
         end
         for (int i = 0; i < RandomPerPhase; i++) send_random();
      end

      req_ch.valid <= 1'b0;
      drain();
      if (errors == 0 && pending == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/abkf_pkg.sv
src/abkf_if.sv
src/abkf_div.sv
src/abkf_dp.sv
src/abkf_ctrl.sv
src/angle_bias_kalman_filter.sv
tb/sv/abkf_scoreboard.sv
tb/sv/testbench.sv
